// File: rtl/core/cnm_pkg.sv
// Shared types and constants for the cron next-match-time block.
package cnm_pkg;

   localparam int unsigned MINUTE_W = 60;
   localparam int unsigned HOUR_W   = 24;
   localparam int unsigned LIMIT_W  = 16;
   localparam int unsigned YEAR_W   = 14;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd3000;
   localparam logic [YEAR_W-1:0]  YEAR_MAX    = 14'd9999;

   // year / 100 as (year * 5243) >> 19, exact for any 14-bit year
   localparam logic [12:0] DIV100_MULT  = 13'd5243;
   localparam int unsigned DIV100_SHIFT = 19;

   typedef struct packed {
      logic [MINUTE_W-1:0] minute_mask;
      logic [HOUR_W-1:0]   hour_mask;
      logic [31:0]         mday_mask;
      logic [6:0]          wday_mask;
      logic [11:0]         month_mask;
      logic [5:0]          now_minute;
      logic [4:0]          now_hour;
      logic [4:0]          now_mday;
      logic [2:0]          now_wday;
      logic [3:0]          now_month;
      logic [YEAR_W-1:0]   now_year;
   } cnm_req_type;

   typedef struct packed {
      logic [5:0]        next_minute;
      logic [4:0]        next_hour;
      logic [4:0]        next_mday;
      logic [2:0]        next_wday;
      logic [3:0]        next_month;
      logic [YEAR_W-1:0] next_year;
      logic              gave_up;
   } cnm_rsp_type;

endpackage

// File: rtl/core/cnm_stream_if.sv
// Valid/ready channel carrying one request or response payload.
interface cnm_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/cron_next_match_time_top.sv
// Next firing time of one cron schedule, found by a day-stepping sequencer.
//
//  channel    dir  handshake                  payload
//  req_chan   in   valid/ready                cnm_req_type (masks, current time)
//  rsp_chan   out  valid/ready                cnm_rsp_type (next time, gave_up)
//  csr_*      in   write enable, no stall     16-bit lookahead limit
//
// Match in this hour or a later hour today: response set in the load state.
// Otherwise one date-step unit advances one day per cycle and gives up after
// lookahead-limit days without a match; an empty minute or hour mask gives up.
// One request in flight; req_chan.ready is high only while idle.
// A stalled response holds until taken. Reset is synchronous, limit resets to 3000.
module cron_next_match_time_top
   import cnm_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   cnm_stream_if.sink          req_chan,
   cnm_stream_if.source        rsp_chan,
   input  logic                csr_write_enable,
   input  logic [LIMIT_W-1:0]  csr_write_data
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_LOAD = 3'd1;
   localparam logic [2:0] ST_YEAR = 3'd2;
   localparam logic [2:0] ST_DAY  = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   localparam logic [MINUTE_W-1:0] MINUTE_ONES = '1;
   localparam logic [HOUR_W-1:0]   HOUR_ONES   = '1;

   function automatic logic [5:0] low_minute(input logic [MINUTE_W-1:0] v);
      logic [5:0] idx;
      idx = '0;
      for (int i = MINUTE_W - 1; i >= 0; i--) begin
         if (v[i]) idx = 6'(i);
      end
      return idx;
   endfunction

   function automatic logic [4:0] low_hour(input logic [HOUR_W-1:0] v);
      logic [4:0] idx;
      idx = '0;
      for (int i = HOUR_W - 1; i >= 0; i--) begin
         if (v[i]) idx = 5'(i);
      end
      return idx;
   endfunction

   function automatic logic [4:0] month_days(input logic [3:0] mon, input logic leap);
      logic [4:0] days;
      unique case (mon)
         4'd1:                   days = leap ? 5'd29 : 5'd28;
         4'd3, 4'd5, 4'd8, 4'd10,
         4'd12, 4'd15:           days = 5'd30;
         default:                days = 5'd31;
      endcase
      return days;
   endfunction

   function automatic logic [2:0] wday_step(input logic [2:0] w);
      logic [2:0] nx;
      unique case (w)
         3'd6:    nx = 3'd0;
         3'd7:    nx = 3'd1;
         default: nx = w + 3'd1;
      endcase
      return nx;
   endfunction

   function automatic logic day_match(input cnm_req_type q, input logic [4:0] mday,
                                      input logic [2:0] wday, input logic [3:0] mon);
      logic [7:0]  wd;
      logic [15:0] mo;
      wd = {1'b0, q.wday_mask};
      mo = {4'b0, q.month_mask};
      return (q.mday_mask[mday] | wd[wday]) & mo[mon];
   endfunction

   function automatic logic [YEAR_W-1:0] sat_year(input logic [YEAR_W:0] y);
      return (y > {1'b0, YEAR_MAX}) ? YEAR_MAX : y[YEAR_W-1:0];
   endfunction

   logic [2:0]          state_ff, state_in;
   logic [LIMIT_W-1:0]  limit_ff;
   cnm_req_type         job_ff;
   cnm_rsp_type         rsp_ff, rsp_in;
   logic [5:0]          min_ff, min_in;
   logic [4:0]          hr_ff, hr_in;
   logic [4:0]          mday_ff, mday_in;
   logic [2:0]          wday_ff, wday_in;
   logic [3:0]          mon_ff, mon_in;
   logic [YEAR_W:0]     year_ff, year_in;
   logic [7:0]          cent_ff, cent_in;     // year / 100
   logic [6:0]          yrem_ff, yrem_in;     // year % 100
   logic [LIMIT_W-1:0]  steps_ff, steps_in;

   logic                req_fire;
   logic                today;
   logic [31:0]         hour_ext;
   logic [MINUTE_W-1:0] min_left;
   logic [HOUR_W-1:0]   hr_left;
   logic [26:0]         cent_prod;
   logic [YEAR_W:0]     cent_x100;
   logic                leap;
   logic [4:0]          len;
   logic [5:0]          mday_inc;
   logic [4:0]          mon_inc;
   logic                mday_wrap;
   logic                year_wrap;
   logic [4:0]          step_mday;
   logic [2:0]          step_wday;
   logic [3:0]          step_mon;

   assign req_fire       = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign rsp_chan.valid = (state_ff == ST_DONE);
   assign rsp_chan.data  = rsp_ff;

   // first-cycle checks on the captured request
   assign today     = day_match(job_ff, job_ff.now_mday, job_ff.now_wday, job_ff.now_month);
   assign hour_ext  = {8'b0, job_ff.hour_mask};
   assign min_left  = job_ff.minute_mask & (MINUTE_ONES << ({1'b0, job_ff.now_minute} + 7'd1));
   assign hr_left   = job_ff.hour_mask & (HOUR_ONES << ({1'b0, job_ff.now_hour} + 6'd1));
   assign cent_prod = 27'(job_ff.now_year) * 27'(DIV100_MULT);
   assign cent_x100 = 15'(cent_ff) * 15'd100;

   // date-step unit
   assign leap      = (year_ff[1:0] == 2'd0) && ((yrem_ff != 7'd0) || (cent_ff[1:0] == 2'd0));
   assign len       = month_days(mon_ff, leap);
   assign mday_inc  = {1'b0, mday_ff} + 6'd1;
   assign mon_inc   = {1'b0, mon_ff} + 5'd1;
   assign mday_wrap = mday_inc > {1'b0, len};
   assign year_wrap = mday_wrap && (mon_inc >= 5'd12);
   assign step_mday = mday_wrap ? 5'd1 : mday_inc[4:0];
   assign step_wday = wday_step(wday_ff);
   assign step_mon  = year_wrap ? 4'd0 : (mday_wrap ? mon_inc[3:0] : mon_ff);

   always_comb begin
      state_in = state_ff;
      rsp_in   = rsp_ff;
      min_in   = min_ff;
      hr_in    = hr_ff;
      mday_in  = mday_ff;
      wday_in  = wday_ff;
      mon_in   = mon_ff;
      year_in  = year_ff;
      cent_in  = cent_ff;
      yrem_in  = yrem_ff;
      steps_in = steps_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) state_in = ST_LOAD;
         end
         ST_LOAD: begin
            mday_in = job_ff.now_mday;
            wday_in = job_ff.now_wday;
            mon_in  = job_ff.now_month;
            year_in = {1'b0, job_ff.now_year};
            cent_in = cent_prod[26:DIV100_SHIFT];
            min_in  = low_minute(job_ff.minute_mask);
            hr_in   = low_hour(job_ff.hour_mask);
            rsp_in.next_minute = low_minute(job_ff.minute_mask);
            rsp_in.next_hour   = job_ff.now_hour;
            rsp_in.next_mday   = job_ff.now_mday;
            rsp_in.next_wday   = job_ff.now_wday;
            rsp_in.next_month  = job_ff.now_month;
            rsp_in.next_year   = sat_year({1'b0, job_ff.now_year});
            rsp_in.gave_up     = 1'b0;
            priority if (job_ff.minute_mask == '0 || job_ff.hour_mask == '0) begin
               rsp_in   = '0;
               rsp_in.gave_up = 1'b1;
               state_in = ST_DONE;
            end else if (today && hour_ext[job_ff.now_hour] && min_left != '0) begin
               rsp_in.next_minute = low_minute(min_left);
               state_in = ST_DONE;
            end else if (today && hr_left != '0) begin
               rsp_in.next_hour = low_hour(hr_left);
               state_in = ST_DONE;
            end else begin
               state_in = ST_YEAR;
            end
         end
         ST_YEAR: begin
            yrem_in  = 7'(year_ff - cent_x100);
            steps_in = '0;
            state_in = ST_DAY;
         end
         ST_DAY: begin
            if (steps_ff >= limit_ff) begin
               rsp_in   = '0;
               rsp_in.gave_up = 1'b1;
               state_in = ST_DONE;
            end else begin
               steps_in = steps_ff + 1'b1;
               mday_in  = step_mday;
               wday_in  = step_wday;
               mon_in   = step_mon;
               if (year_wrap) begin
                  year_in = year_ff + 1'b1;
                  if (yrem_ff == 7'd99) begin
                     yrem_in = '0;
                     cent_in = cent_ff + 1'b1;
                  end else begin
                     yrem_in = yrem_ff + 1'b1;
                  end
               end
               if (day_match(job_ff, step_mday, step_wday, step_mon)) begin
                  rsp_in.next_minute = min_ff;
                  rsp_in.next_hour   = hr_ff;
                  rsp_in.next_mday   = step_mday;
                  rsp_in.next_wday   = step_wday;
                  rsp_in.next_month  = step_mon;
                  rsp_in.next_year   = sat_year(year_wrap ? year_ff + 1'b1 : year_ff);
                  rsp_in.gave_up     = 1'b0;
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (rsp_chan.ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         limit_ff <= LIMIT_RESET;
      end else begin
         state_ff <= state_in;
         if (csr_write_enable) limit_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) job_ff <= req_chan.data;
      rsp_ff   <= rsp_in;
      min_ff   <= min_in;
      hr_ff    <= hr_in;
      mday_ff  <= mday_in;
      wday_ff  <= wday_in;
      mon_ff   <= mon_in;
      year_ff  <= year_in;
      cent_ff  <= cent_in;
      yrem_ff  <= yrem_in;
      steps_ff <= steps_in;
   end

endmodule

// File: rtl/core/cnm_checker.sv
// Port-level checks for the cron next-match-time block, bound to its top level.
module cnm_checker
   import cnm_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input cnm_rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("response dropped while stalled");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while another is in flight");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && req_ready))
      else $error("ready for a request while a response waits");

   a_gave_up_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.gave_up) |->
         (rsp_data.next_minute == '0 && rsp_data.next_hour == '0 &&
          rsp_data.next_mday == '0 && rsp_data.next_wday == '0 &&
          rsp_data.next_month == '0 && rsp_data.next_year == '0))
      else $error("give-up response carries a time");

   a_time_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.gave_up) |->
         (rsp_data.next_minute < 6'd60 && rsp_data.next_hour < 5'd24 &&
          rsp_data.next_year <= YEAR_MAX))
      else $error("response time out of range");

endmodule

bind cron_next_match_time_top cnm_checker u_cnm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_data  (rsp_chan.data)
);
